### hdl/ffba_pkg.sv
// package: types, constants and codes for the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;
    localparam int unsigned ARENA_MAX_BYTES_DEF = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 16;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    localparam logic [1:0] ADDR_ARENA = 2'd0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_RD,
        ST_WAIT,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        PH_AT_TAIL,
        PH_WALK,
        PH_SPLIT_WR2,
        PH_MARK,
        PH_FREE_B,
        PH_FREE_NX,
        PH_RA_B,
        PH_RA_NX,
        PH_RA_WR2,
        PH_RA_MARK,
        PH_MV_FREE,
        PH_MV_NX,
        PH_FIN
    } t_phase;
endpackage

### hdl/ffba_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ffba_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/first_fit_block_allocator.sv
// top level: first-fit block allocator with split and coalesce
//
// usage: a request word (i_req_type, i_req_size, i_req_addr, i_addr_present)
// is taken at a clock edge with i_start high and o_busy low. the block then
// walks block headers in its header ram, each header read going through
// address, registered read and evaluate, and writes back split, merge and
// mark headers at most one per cycle. the result word appears on
// o_result_* for exactly one cycle with o_done high; it cannot be stalled.
// the header ram's single port sets how long each request takes. busy drops
// in the done cycle, so the next word can be taken there.
// configuration: an apb write of arena_bytes at address 0 taken while idle
// re-initialises the arena (one free block, tail at zero) while busy is high.
// after reset the same initialisation runs once. no clearing pass is used:
// the header walk reads only headers that have been written.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
    parameter int unsigned ARENA_MAX_BYTES = ffba_pkg::ARENA_MAX_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [16:0] i_req_size,
    input  logic [15:0] i_req_addr,
    input  logic        i_addr_present,
    output logic        o_done,
    output logic [15:0] o_result_addr,
    output logic        o_granted,
    output logic        o_moved,
    output logic [16:0] o_copy_bytes
);
    import ffba_pkg::*;

    localparam int unsigned AW = $clog2(ARENA_MAX_BYTES);
    localparam int unsigned VW = ((AW > 16) ? AW : 16) + 3;
    localparam logic [VW-1:0] HB = VW'(HEADER_BYTES);
    localparam logic [VW-1:0] AMAX = VW'(ARENA_MAX_BYTES);
    localparam int unsigned DW = VW + 1;

    t_state r_state, n_state;
    t_phase r_ph, n_ph;
    logic [16:0] r_arena, n_arena;
    logic [VW-1:0] r_len, n_len;
    logic [VW-1:0] r_tail, n_tail;
    logic [1:0] r_type, n_type;
    logic [VW-1:0] r_want, n_want;
    logic [VW-1:0] r_raddr, n_raddr;
    logic r_pres, n_pres;
    logic [VW-1:0] r_cur, n_cur;
    logic [VW-1:0] r_b, n_b;
    logic [VW-1:0] r_pay, n_pay;
    logic r_bfree, n_bfree;
    logic [VW-1:0] r_nx, n_nx;
    logic [VW-1:0] r_res, n_res;
    logic r_ok, n_ok, r_mv, n_mv;
    logic [VW-1:0] r_copy, n_copy;
    logic [VW-1:0] r_rd_off, n_rd_off;
    logic r_done, n_done;

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata, mem_rdata;
    logic [VW-1:0] wr_off, wr_size, wr_clip;
    logic wr_free, wr_en;
    logic rd_ok;
    logic [VW-1:0] rd_size;
    logic rd_fr;
    logic cfg_wr;
    logic [VW+1:0] sum;

    ffba_ram #(.WIDTH(DW), .DEPTH(ARENA_MAX_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ARENA) ? {15'd0, r_arena} : 32'd0;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_granted = r_done & r_ok;
    assign o_moved = r_done & r_mv;
    assign o_result_addr = (r_done & r_ok) ? r_res[15:0] : 16'd0;
    assign o_copy_bytes = (r_done & r_mv) ? r_copy[16:0] : 17'd0;

    // header read: entry is valid only when it lies within the arena
    assign rd_ok = ({2'b00, r_rd_off} + {2'b00, HB}) <= {2'b00, r_len};
    assign rd_size = rd_ok ? mem_rdata[VW:1] : '0;
    assign rd_fr = rd_ok & mem_rdata[0];

    assign wr_clip = (wr_size > r_len) ? r_len : wr_size;
    assign mem_we = wr_en && (({2'b00, wr_off} + {2'b00, HB}) <= {2'b00, r_len});
    assign mem_wdata = {wr_clip, wr_free};
    assign mem_addr = wr_en ? wr_off[AW-1:0] : r_rd_off[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ph <= PH_FIN;
            r_arena <= 17'h10000;
            r_len <= '0;
            r_tail <= '0;
            r_done <= 1'b0;
            r_ok <= 1'b0;
            r_mv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            r_arena <= n_arena;
            r_len <= n_len;
            r_tail <= n_tail;
            r_done <= n_done;
            r_ok <= n_ok;
            r_mv <= n_mv;
        end
        r_type <= n_type;
        r_want <= n_want;
        r_raddr <= n_raddr;
        r_pres <= n_pres;
        r_cur <= n_cur;
        r_b <= n_b;
        r_pay <= n_pay;
        r_bfree <= n_bfree;
        r_nx <= n_nx;
        r_res <= n_res;
        r_copy <= n_copy;
        r_rd_off <= n_rd_off;
    end

    always_comb begin
        n_state = r_state;
        n_ph = r_ph;
        n_arena = r_arena;
        n_len = r_len;
        n_tail = r_tail;
        n_type = r_type;
        n_want = r_want;
        n_raddr = r_raddr;
        n_pres = r_pres;
        n_cur = r_cur;
        n_b = r_b;
        n_pay = r_pay;
        n_bfree = r_bfree;
        n_nx = r_nx;
        n_res = r_res;
        n_ok = r_ok;
        n_mv = r_mv;
        n_copy = r_copy;
        n_rd_off = r_rd_off;
        n_done = 1'b0;
        wr_en = 1'b0;
        wr_off = '0;
        wr_size = '0;
        wr_free = 1'b0;
        sum = '0;

        if (cfg_wr && paddr == ADDR_ARENA) begin
            n_arena = pwdata[16:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (cfg_wr && paddr == ADDR_ARENA) begin
                    n_state = ST_INIT;
                end else if (i_start) begin
                    n_type = i_req_type;
                    n_want = VW'(i_req_size);
                    n_raddr = VW'(i_req_addr);
                    n_pres = i_addr_present;
                    n_ok = 1'b0;
                    n_mv = 1'b0;
                    n_res = '0;
                    n_copy = '0;
                    n_state = ST_RD;
                    priority if (i_req_type == REQ_ALLOC ||
                                 (i_req_type == REQ_REALLOC && !i_addr_present)) begin
                        n_ph = PH_AT_TAIL;
                        n_rd_off = r_tail;
                    end else if (i_req_type == REQ_FREE && i_addr_present) begin
                        n_ph = PH_FREE_B;
                        n_b = VW'(i_req_addr) - HB;
                        n_rd_off = VW'(i_req_addr) - HB;
                        if (VW'(i_req_addr) < HB) begin
                            n_state = ST_DONE;
                        end
                    end else if (i_req_type == REQ_REALLOC) begin
                        n_ph = PH_RA_B;
                        n_b = VW'(i_req_addr) - HB;
                        n_rd_off = VW'(i_req_addr) - HB;
                        if (VW'(i_req_addr) < HB) begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INIT: begin
                // clamp the arena length and lay down one free block
                priority if (VW'(r_arena) < HB) begin
                    n_len = HB;
                end else if (VW'(r_arena) > AMAX) begin
                    n_len = AMAX;
                end else begin
                    n_len = VW'(r_arena);
                end
                n_tail = '0;
                n_state = ST_EVAL;
                n_ph = PH_FIN;
                n_ok = 1'b0;
            end
            ST_RD: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_DONE;
                unique case (r_ph)
                    PH_FIN: begin
                        // init write of the first block
                        wr_en = 1'b1;
                        wr_off = '0;
                        wr_size = r_len - HB;
                        wr_free = 1'b1;
                        n_state = ST_IDLE;
                    end
                    PH_AT_TAIL: begin
                        if (rd_fr && r_want <= rd_size) begin
                            n_cur = r_rd_off;
                            n_pay = rd_size;
                            n_tail = (r_want + HB <= rd_size) ?
                                     r_rd_off + HB + r_want : r_rd_off + HB + rd_size;
                            n_ph = PH_SPLIT_WR2;
                            n_state = ST_EVAL;
                        end else if (r_tail != '0 && r_len != '0) begin
                            n_rd_off = '0;
                            n_ph = PH_WALK;
                            n_state = ST_RD;
                        end else begin
                            n_state = (r_type == REQ_REALLOC && r_pres) ? ST_DONE : ST_DONE;
                        end
                    end
                    PH_WALK: begin
                        if (rd_fr && r_want <= rd_size) begin
                            n_cur = r_rd_off;
                            n_pay = rd_size;
                            n_ph = PH_SPLIT_WR2;
                            n_state = ST_EVAL;
                        end else begin
                            sum = {2'b00, r_rd_off} + {2'b00, HB} + {2'b00, rd_size};
                            if (sum < {2'b00, r_tail} && sum < {2'b00, r_len}) begin
                                n_rd_off = sum[VW-1:0];
                                n_state = ST_RD;
                            end
                        end
                    end
                    PH_SPLIT_WR2: begin
                        // remainder header (free), then mark chosen block
                        if (r_want + HB <= r_pay) begin
                            wr_en = 1'b1;
                            wr_off = r_cur + HB + r_want;
                            wr_size = r_pay - r_want - HB;
                            wr_free = 1'b1;
                            n_pay = r_want;
                        end
                        n_ph = PH_MARK;
                        n_state = ST_EVAL;
                    end
                    PH_MARK: begin
                        wr_en = 1'b1;
                        wr_off = r_cur;
                        wr_size = r_pay;
                        wr_free = 1'b0;
                        if (r_mv) begin
                            n_res = r_cur + HB;
                            n_ph = PH_MV_FREE;
                            n_rd_off = r_b;
                            n_state = ST_RD;
                        end else begin
                            n_ok = 1'b1;
                            n_res = r_cur + HB;
                        end
                    end
                    PH_FREE_B, PH_MV_FREE: begin
                        if (rd_ok) begin
                            wr_en = 1'b1;
                            wr_off = r_rd_off;
                            wr_size = rd_size;
                            wr_free = 1'b1;
                            n_pay = rd_size;
                            n_nx = r_rd_off + HB + rd_size;
                            n_rd_off = r_rd_off + HB + rd_size;
                            n_ph = (r_ph == PH_FREE_B) ? PH_FREE_NX : PH_MV_NX;
                            n_state = ST_RD;
                        end
                        if (r_ph == PH_MV_FREE) begin
                            n_ok = 1'b1;
                        end
                    end
                    PH_FREE_NX, PH_MV_NX: begin
                        if (rd_fr) begin
                            wr_en = 1'b1;
                            wr_off = r_b;
                            wr_size = r_pay + rd_size + HB;
                            wr_free = 1'b1;
                            if (r_tail == r_nx) begin
                                n_tail = r_b;
                            end
                        end
                        if (r_ph == PH_FREE_NX) begin
                            n_ok = 1'b1;
                            n_res = '0;
                        end
                    end
                    PH_RA_B: begin
                        if (rd_ok) begin
                            n_pay = rd_size;
                            n_bfree = rd_fr;
                            n_nx = r_rd_off + HB + rd_size;
                            if (r_want <= rd_size) begin
                                n_ok = 1'b1;
                                n_res = r_raddr;
                            end else begin
                                n_rd_off = r_rd_off + HB + rd_size;
                                n_ph = PH_RA_NX;
                                n_state = ST_RD;
                            end
                        end
                    end
                    PH_RA_NX: begin
                        sum = {2'b00, r_pay} + {2'b00, HB} + {2'b00, rd_size};
                        if (rd_fr && {2'b00, r_want} <= sum) begin
                            // grow in place: merged size, clipped to arena
                            n_pay = (sum[VW-1:0] > r_len) ? r_len : sum[VW-1:0];
                            n_ph = PH_RA_WR2;
                            n_state = ST_EVAL;
                        end else begin
                            n_mv = 1'b1;
                            n_copy = r_pay;
                            n_ph = PH_AT_TAIL;
                            n_rd_off = r_tail;
                            n_state = ST_RD;
                        end
                    end
                    PH_RA_WR2: begin
                        if (r_want + HB <= r_pay) begin
                            wr_en = 1'b1;
                            wr_off = r_b + HB + r_want;
                            wr_size = r_pay - r_want - HB;
                            wr_free = 1'b1;
                            if (r_tail == r_nx) begin
                                n_tail = r_b + HB + r_want;
                            end
                            n_pay = r_want;
                        end else if (r_tail == r_nx) begin
                            n_tail = r_b + HB + r_pay;
                        end
                        n_ph = PH_RA_MARK;
                        n_state = ST_EVAL;
                    end
                    PH_RA_MARK: begin
                        wr_en = 1'b1;
                        wr_off = r_b;
                        wr_size = r_pay;
                        wr_free = r_bfree;
                        n_ok = 1'b1;
                        n_res = r_raddr;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                n_done = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_state == ST_EVAL && n_state == ST_DONE && r_mv && !n_ok) begin
            n_mv = 1'b0;
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while busy");
    a_moved_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_moved |-> o_granted)
        else $error("moved without grant");
    a_tail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= r_len || r_state == ST_INIT)
        else $error("tail beyond arena");
endmodule
